/* rtl/sqsp_pkg.sv */
// Shared constants for the square spiral coordinate generator.
`default_nettype none

package sqsp_pkg;

    // Default number of step index bits taken from the input.
    localparam int INDEX_BITS_DEF = 20;

    // Width of each signed coordinate offset.
    localparam int OUT_W = 11;

endpackage : sqsp_pkg

`default_nettype wire

/* rtl/square_spiral_coordinates.sv */
// Square spiral step index to signed column and row offsets, fully pipelined.
//
// The input channel (in_valid, in_stall, step_index) takes one step index per beat.
// The output channel (out_valid, out_stall, col_offset, row_offset) gives one
// pair of two's complement offsets per beat, in input order.
// Internally k = step_index + 1 goes through a restoring square root pipeline
// that settles one root bit per stage, so the root of k and its remainder
// k - r*r leave the last stage together. A final stage picks the ring edge.
// An accepted beat passes the input register, the root stages and the output register,
// where RW = (INDEX_BITS + 2) / 2 is the root width, so 11 bits at the default 20.
// Throughput is one beat per cycle while the receiver does not stall; every
// root stage is one compare and subtract. When the receiver stalls a valid
// result, the whole pipeline holds and in_stall rises in the same cycle;
// nothing is dropped or repeated. Reset clears only the valid bits.
`default_nettype none

module square_spiral_coordinates #(
    parameter int INDEX_BITS = sqsp_pkg::INDEX_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [INDEX_BITS-1:0]             step_index,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [sqsp_pkg::OUT_W-1:0]      col_offset,
    output logic signed [sqsp_pkg::OUT_W-1:0]      row_offset
);
    import sqsp_pkg::*;

    localparam int KW = INDEX_BITS + 1;
    localparam int RW = (KW + 1) / 2;
    localparam int PW = 2 * RW;
    localparam int WW = (RW + 2 > OUT_W) ? RW + 2 : OUT_W;

    logic          advance;
    logic          valid_reg [0:RW];
    logic [KW-1:0] k_reg     [0:RW];
    logic [RW:0]   rem_reg   [0:RW];
    logic [RW-1:0] root_reg  [0:RW];

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] col_reg;
    logic signed [OUT_W-1:0] row_reg;
    logic signed [OUT_W-1:0] col_next;
    logic signed [OUT_W-1:0] row_next;

    // The pipeline moves unless a finished result is being held back.
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            k_reg[0]    <= {1'b0, step_index} + KW'(1);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar s = 1; s <= RW; s++)
    begin : g_root
        localparam int I = RW - s;

        logic [PW-1:0] kpad;
        logic [RW+2:0] acc;
        logic [RW+2:0] trial;
        logic [RW+2:0] diff;
        logic          take;

        // Bring down the next two bits of k and try to set the next root bit.
        always_comb
        begin
            kpad  = PW'(k_reg[s-1]);
            acc   = {rem_reg[s-1], kpad[2*I+1:2*I]};
            trial = {1'b0, root_reg[s-1], 2'b01};
            diff  = acc - trial;
            take  = (acc >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                k_reg[s]    <= k_reg[s-1];
                rem_reg[s]  <= take ? diff[RW:0] : acc[RW:0];
                root_reg[s] <= {root_reg[s-1][RW-2:0], take};
            end
        end
    end

    // Edge selection from the root r and the remainder k - r*r.
    always_comb
    begin
        logic signed [WW-1:0] rs;
        logic signed [WW-1:0] ms;
        logic signed [WW-1:0] hl;
        logic signed [WW-1:0] hu;
        logic signed [WW-1:0] col_w;
        logic signed [WW-1:0] row_w;
        logic                 square;
        logic                 first_edge;

        rs         = $signed(WW'(root_reg[RW]));
        ms         = $signed(WW'(rem_reg[RW]));
        hl         = rs >>> 1;
        hu         = (rs + WW'(1)) >>> 1;
        square     = (rem_reg[RW] == '0);
        first_edge = (ms <= rs + WW'(1));

        if (!root_reg[RW][0])
        begin
            if (square)
            begin
                col_w = WW'(1) - hl;
                row_w = hl;
            end
            else if (first_edge)
            begin
                col_w = -hl;
                row_w = hl - (ms - WW'(1));
            end
            else
            begin
                col_w = -hl + (ms - rs - WW'(1));
                row_w = -hl;
            end
        end
        else
        begin
            if (square)
            begin
                col_w = hl;
                row_w = -hl;
            end
            else if (first_edge)
            begin
                col_w = hu;
                row_w = -hu + ms;
            end
            else
            begin
                col_w = hu - (ms - rs - WW'(1));
                row_w = hu;
            end
        end

        col_next = col_w[OUT_W-1:0];
        row_next = row_w[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= valid_reg[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign col_offset = col_reg;
    assign row_offset = row_reg;

    // A valid root leaving the last stage always becomes a result beat.
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && valid_reg[RW]) |=> out_valid_reg)
        else $error("root stage result did not reach the output register");

    // The remainder of a finished root never exceeds twice the root.
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[RW] |-> (rem_reg[RW] <= {root_reg[RW], 1'b0}))
        else $error("square root remainder out of range");

    // A frozen pipeline keeps its first stage intact.
    a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && valid_reg[0]) |=> (valid_reg[0] && $stable(k_reg[0])))
        else $error("first stage changed while the pipeline was held");

    // The input only stalls behind a result that is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

endmodule : square_spiral_coordinates

`default_nettype wire
